FILE: hw/rtl/sst_pkg.sv
// ----------------------------------------------------------------------------
// sst_pkg
// Shared types and constants for the sparse-set slot table.
// ----------------------------------------------------------------------------
package sst_pkg;

    localparam int ENTITIES = 256;
    localparam int ID_W     = 8;
    localparam int GEN_W    = 16;
    localparam int CNT_W    = 9;
    localparam int ST_W     = 3;
    localparam int MODE_W   = 2;

    localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_GET    = 2'd2;

    localparam logic [ST_W-1:0] ST_OK           = 3'd0;
    localparam logic [ST_W-1:0] ST_NOT_FOUND    = 3'd1;
    localparam logic [ST_W-1:0] ST_PRESENT      = 3'd2;
    localparam logic [ST_W-1:0] ST_FULL         = 3'd3;
    localparam logic [ST_W-1:0] ST_GEN_MISMATCH = 3'd4;

    // One dense slot: the owning entity and its generation.
    typedef struct packed {
        logic [ID_W-1:0]  owner;
        logic [GEN_W-1:0] gen;
    } t_dense;

endpackage

FILE: hw/rtl/sst_ram.sv
// ----------------------------------------------------------------------------
// sst_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/sparse_set_slot_table.sv
// ----------------------------------------------------------------------------
// sparse_set_slot_table
// Maps entity ids to packed dense slots with generation checks.
// ----------------------------------------------------------------------------
// Result path: an add, a mode-3 beat or an entity that is not mapped is answered
// from S_MAP; a get, or a remove that fails its owner and generation check or
// frees the last slot, from S_DEN; a remove that moves the last entry into the
// hole, from S_LAST. One beat is in flight and busy drops in the result cycle,
// so a new beat is taken only once the last one is through.
// Synchronous active-low reset empties the map and the count; results never stall.
// ----------------------------------------------------------------------------
module sparse_set_slot_table
    import sst_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [MODE_W-1:0] i_mode,
    input  logic [ID_W-1:0]  i_entity_id,
    input  logic [GEN_W-1:0] i_entity_gen,
    output logic             o_valid,
    output logic [ST_W-1:0]  o_status,
    output logic [ID_W-1:0]  o_slot_index,
    output logic             o_moved_valid,
    output logic [ID_W-1:0]  o_moved_from,
    output logic [CNT_W-1:0] o_entry_total
);

    // Sequencer states. S_MAP has the sparse-map read data, S_DEN the dense
    // entry of the entity's own slot, S_LAST the dense entry of the last slot.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MAP  = 2'd1;
    localparam logic [1:0] S_DEN  = 2'd2;
    localparam logic [1:0] S_LAST = 2'd3;

    logic [1:0]          r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [ENTITIES-1:0] r_valid, n_valid;
    logic                r_hit;
    logic [MODE_W-1:0]   r_mode;
    logic [ID_W-1:0]     r_id;
    logic [GEN_W-1:0]    r_gen;
    logic [ID_W-1:0]     r_slot, n_slot;

    // Result register; the strobe is control state, the fields are payload.
    logic                r_done, n_done;
    logic [ST_W-1:0]     r_status, n_status;
    logic [ID_W-1:0]     r_slot_out, n_slot_out;
    logic                r_mv, n_mv;
    logic [ID_W-1:0]     r_from, n_from;
    logic [CNT_W-1:0]    r_total, n_total;

    // RAM ports.
    logic                map_we;
    logic [ID_W-1:0]     map_waddr, map_wdata, map_raddr, map_rdata;
    logic                den_we;
    logic [ID_W-1:0]     den_waddr, den_raddr;
    t_dense              den_wdata, den_rdata;

    logic                accept;
    logic [ID_W-1:0]     last_slot;
    logic                den_match;

    assign accept    = start && !busy;
    assign busy      = (r_state != S_IDLE);
    assign last_slot = ID_W'(r_count - CNT_W'(1));
    // The owner check is redundant while the table is consistent, but it is
    // cheap and keeps a remove from disturbing a foreign slot.
    assign den_match = (den_rdata.owner == r_id) && (den_rdata.gen == r_gen);

    // Sparse map: dense slot of each entity. Emptiness lives in r_valid.
    sst_ram #(.WIDTH(ID_W), .DEPTH(ENTITIES)) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_raddr (map_raddr),
        .o_rdata (map_rdata)
    );

    // Dense store: owner and generation of each occupied slot. Slots at or
    // above the count are never read before they are written.
    sst_ram #(.WIDTH($bits(t_dense)), .DEPTH(ENTITIES)) u_dense_ram (
        .i_clk   (i_clk),
        .i_we    (den_we),
        .i_waddr (den_waddr),
        .i_wdata (den_wdata),
        .i_raddr (den_raddr),
        .o_rdata (den_rdata)
    );

    // The map read is launched on the accept edge straight from the input
    // port, so the slot is ready in S_MAP. All writes of a beat land on its
    // result edge, before the next beat can be accepted, so no forwarding
    // is needed.
    assign map_raddr = (r_state == S_IDLE) ? i_entity_id : r_id;

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_valid    = r_valid;
        n_slot     = r_slot;
        n_done     = 1'b0;
        n_status   = r_status;
        n_slot_out = r_slot_out;
        n_mv       = r_mv;
        n_from     = r_from;
        n_total    = r_total;
        map_we     = 1'b0;
        map_waddr  = r_id;
        map_wdata  = r_count[ID_W-1:0];
        den_we     = 1'b0;
        den_waddr  = r_count[ID_W-1:0];
        den_wdata  = '{owner: r_id, gen: r_gen};
        den_raddr  = map_rdata;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_MAP;
                end
            end
            S_MAP: begin
                // Default answer: not found with the fields that go unused at 0.
                n_done     = 1'b1;
                n_state    = S_IDLE;
                n_status   = ST_NOT_FOUND;
                n_slot_out = '0;
                n_mv       = 1'b0;
                n_from     = '0;
                n_total    = r_count;
                if (r_mode == MODE_ADD) begin
                    if (r_hit) begin
                        n_status   = ST_PRESENT;
                        n_slot_out = map_rdata;
                    end else if (r_count == CNT_W'(ENTITIES)) begin
                        n_status = ST_FULL;
                    end else begin
                        map_we         = 1'b1;
                        den_we         = 1'b1;
                        n_valid[r_id]  = 1'b1;
                        n_count        = r_count + CNT_W'(1);
                        n_status       = ST_OK;
                        n_slot_out     = r_count[ID_W-1:0];
                        n_total        = r_count + CNT_W'(1);
                    end
                end else if ((r_mode == MODE_GET || r_mode == MODE_REMOVE) && r_hit) begin
                    // Look up the dense entry; no result this cycle.
                    n_done  = 1'b0;
                    n_state = S_DEN;
                    n_slot  = map_rdata;
                end
            end
            S_DEN: begin
                n_done     = 1'b1;
                n_state    = S_IDLE;
                n_mv       = 1'b0;
                n_from     = '0;
                n_total    = r_count;
                n_slot_out = r_slot;
                if (r_mode == MODE_GET) begin
                    n_status = (den_rdata.gen == r_gen) ? ST_OK : ST_GEN_MISMATCH;
                end else if (!den_match) begin
                    n_status   = ST_NOT_FOUND;
                    n_slot_out = '0;
                end else if (last_slot == r_slot) begin
                    // The entity holds the last slot: just drop it.
                    n_valid[r_id] = 1'b0;
                    n_count       = r_count - CNT_W'(1);
                    n_status      = ST_OK;
                    n_total       = r_count - CNT_W'(1);
                end else begin
                    // Fetch the last entry to move it into the hole.
                    n_done    = 1'b0;
                    n_state   = S_LAST;
                    den_raddr = last_slot;
                end
            end
            S_LAST: begin
                // Move the last entry into the hole and repoint its owner.
                den_we        = 1'b1;
                den_waddr     = r_slot;
                den_wdata     = den_rdata;
                map_we        = 1'b1;
                map_waddr     = den_rdata.owner;
                map_wdata     = r_slot;
                n_valid[r_id] = 1'b0;
                n_count       = r_count - CNT_W'(1);
                n_done        = 1'b1;
                n_state       = S_IDLE;
                n_status      = ST_OK;
                n_slot_out    = r_slot;
                n_mv          = 1'b1;
                n_from        = last_slot;
                n_total       = r_count - CNT_W'(1);
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode <= i_mode;
            r_id   <= i_entity_id;
            r_gen  <= i_entity_gen;
            r_hit  <= r_valid[i_entity_id];
        end
        r_slot     <= n_slot;
        r_status   <= n_status;
        r_slot_out <= n_slot_out;
        r_mv       <= n_mv;
        r_from     <= n_from;
        r_total    <= n_total;
    end

    assign o_valid       = r_done;
    assign o_status      = r_status;
    assign o_slot_index  = r_slot_out;
    assign o_moved_valid = r_mv;
    assign o_moved_from  = r_from;
    assign o_entry_total = r_total;

    // The count never passes the table size.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(ENTITIES))
        else $error("occupied count beyond table size");

    // An accepted beat always starts with the map lookup.
    a_accept_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state == S_MAP)
        else $error("accepted beat did not start the map lookup");

    // A result only follows a busy cycle.
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_done |-> busy)
        else $error("result raised while idle");

    // A move always comes from the slot that just became the new end.
    a_move_from_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_moved_valid) |-> o_moved_from == o_entry_total[ID_W-1:0])
        else $error("moved entry is not the former last slot");

    // Full is only reported on a full table.
    a_full_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_FULL) |-> o_entry_total == CNT_W'(ENTITIES))
        else $error("full reported on a table with free slots");

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives add, remove, get and mode-3 beats into the sparse-set table and checks
// every result beat against a cycle-free model of the map and dense store.
// ----------------------------------------------------------------------------
module testbench
    import sst_pkg::*;
();

    // Mode 3 is not an operation; the table must answer it with not found.
    localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_BEATS = 1950;
    // The last stretch of beats goes in back to back, with no idle cycles.
    localparam int TAIL_BEATS   = 200;
    // Cycles to keep watching after the last expected result has arrived.
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [ID_W-1:0]   id;
        logic [GEN_W-1:0]  gen;
    } t_beat;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [ID_W-1:0]  slot;
        logic             moved;
        logic [ID_W-1:0]  from;
        logic [CNT_W-1:0] total;
    } t_result;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              start         = 1'b0;
    logic [MODE_W-1:0] i_mode        = '0;
    logic [ID_W-1:0]   i_entity_id   = '0;
    logic [GEN_W-1:0]  i_entity_gen  = '0;
    logic              busy;
    logic              o_valid;
    logic [ST_W-1:0]   o_status;
    logic [ID_W-1:0]   o_slot_index;
    logic              o_moved_valid;
    logic [ID_W-1:0]   o_moved_from;
    logic [CNT_W-1:0]  o_entry_total;

    sparse_set_slot_table dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_mode        (i_mode),
        .i_entity_id   (i_entity_id),
        .i_entity_gen  (i_entity_gen),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_slot_index  (o_slot_index),
        .o_moved_valid (o_moved_valid),
        .o_moved_from  (o_moved_from),
        .o_entry_total (o_entry_total)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Prediction. The map holds a valid bit and a dense slot per entity; the
    // dense store holds owner and generation per slot. Only slots below the
    // live count are ever read, so the store needs no reset value.
    // ------------------------------------------------------------------------
    logic             slot_live [ENTITIES];
    logic [ID_W-1:0]  slot_of   [ENTITIES];
    t_dense           dense_tab [ENTITIES];
    logic [CNT_W-1:0] live_count;

    t_result table_results [$];
    t_beat   pending_beats [$];
    int      fail_count  = 0;
    int      cycle_count = 0;

    initial begin
        for (int k = 0; k < ENTITIES; k++) begin
            slot_live[k] = 1'b0;
            slot_of[k]   = '0;
        end
        live_count = '0;
    end

    function automatic t_result predict_table(input t_beat b);
        t_result         r;
        logic [ID_W-1:0] s;
        logic [ID_W-1:0] last;
        r = '0;
        if (b.mode == MODE_ADD) begin
            if (slot_live[b.id]) begin
                r.status = ST_PRESENT;
                r.slot   = slot_of[b.id];
            end else if (live_count == ENTITIES) begin
                r.status = ST_FULL;
            end else begin
                s              = live_count[ID_W-1:0];
                dense_tab[s]   = '{owner: b.id, gen: b.gen};
                slot_live[b.id] = 1'b1;
                slot_of[b.id]  = s;
                live_count     = live_count + 1'b1;
                r.status       = ST_OK;
                r.slot         = s;
            end
        end else if ((b.mode != MODE_REMOVE && b.mode != MODE_GET) || !slot_live[b.id]) begin
            r.status = ST_NOT_FOUND;
        end else begin
            s = slot_of[b.id];
            if (b.mode == MODE_GET) begin
                r.slot   = s;
                r.status = (dense_tab[s].gen == b.gen) ? ST_OK : ST_GEN_MISMATCH;
            end else if (dense_tab[s].owner != b.id || dense_tab[s].gen != b.gen) begin
                // A failed remove hides the slot and reports not found.
                r.status = ST_NOT_FOUND;
            end else begin
                slot_live[b.id] = 1'b0;
                r.status        = ST_OK;
                r.slot          = s;
                last            = live_count[ID_W-1:0] - 1'b1;
                // Fill the hole with the last dense entry unless the hole is last.
                if (last != s) begin
                    dense_tab[s]                   = dense_tab[last];
                    slot_of[dense_tab[last].owner] = s;
                    r.moved                        = 1'b1;
                    r.from                         = last;
                end
                live_count = live_count - 1'b1;
            end
        end
        r.total = live_count;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus planning. A light tracker of which ids are live, and with what
    // generation, lets most beats be well formed: gets and removes aimed at
    // live entities with the right generation, adds aimed at free ids.
    // ------------------------------------------------------------------------
    logic             plan_live [ENTITIES];
    logic [GEN_W-1:0] plan_gen  [ENTITIES];
    int               plan_count = 0;

    task automatic queue_beat(input logic [MODE_W-1:0] mode, input logic [ID_W-1:0] id,
                              input logic [GEN_W-1:0] gen);
        pending_beats.push_back('{mode: mode, id: id, gen: gen});
        if (mode == MODE_ADD && !plan_live[id] && plan_count < ENTITIES) begin
            plan_live[id] = 1'b1;
            plan_gen[id]  = gen;
            plan_count++;
        end else if (mode == MODE_REMOVE && plan_live[id] && plan_gen[id] == gen) begin
            plan_live[id] = 1'b0;
            plan_count--;
        end
    endtask

    // Returns an id whose live state matches want_live, or -1 if none exists.
    function automatic int pick_id(input logic want_live);
        int base;
        int id;
        base = $urandom_range(0, ENTITIES - 1);
        for (int k = 0; k < ENTITIES; k++) begin
            id = (base + k) % ENTITIES;
            if (plan_live[id] == want_live)
                return id;
        end
        return -1;
    endfunction

    task automatic plan_random_beats();
        int               target;
        int               r;
        int               id;
        logic             grow;
        logic [GEN_W-1:0] gen;
        target = ENTITIES;
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            // Steer the occupancy toward a target, often empty or completely full.
            if (plan_count == target) begin
                r      = $urandom_range(0, 9);
                target = (r < 3) ? ENTITIES : (r < 5) ? 0 : $urandom_range(0, ENTITIES);
            end
            grow = (plan_count < target);
            r    = $urandom_range(0, 99);
            gen  = GEN_W'($urandom);
            if (r < 60) begin
                if ((r < 50) == grow) begin
                    id = pick_id(1'b0);
                    if (id < 0)
                        id = $urandom_range(0, ENTITIES - 1);
                    queue_beat(MODE_ADD, ID_W'(id), gen);
                end else begin
                    id = pick_id(1'b1);
                    if (id < 0)
                        queue_beat(MODE_REMOVE, ID_W'($urandom_range(0, ENTITIES - 1)), gen);
                    else
                        queue_beat(MODE_REMOVE, ID_W'(id), plan_gen[id]);
                end
            end else if (r < 90) begin
                // Beats aimed at a live entity: good and bad generations.
                id = pick_id(1'b1);
                if (id < 0)
                    id = $urandom_range(0, ENTITIES - 1);
                if (r < 75)
                    queue_beat(MODE_GET, ID_W'(id), plan_gen[id]);
                else if (r < 80)
                    queue_beat(MODE_GET, ID_W'(id), plan_gen[id] ^ (16'h1 << $urandom_range(0, 15)));
                else if (r < 85)
                    queue_beat(MODE_REMOVE, ID_W'(id),
                               plan_gen[id] ^ (16'h1 << $urandom_range(0, 15)));
                else
                    queue_beat(MODE_ADD, ID_W'(id), gen);
            end else if (r < 95) begin
                id = pick_id(1'b0);
                if (id < 0)
                    id = $urandom_range(0, ENTITIES - 1);
                queue_beat($urandom_range(0, 1) ? MODE_GET : MODE_REMOVE, ID_W'(id), gen);
            end else begin
                // Noise: any mode, including the unused one, with random content.
                queue_beat(MODE_W'($urandom_range(0, (1 << MODE_W) - 1)),
                           ID_W'($urandom_range(0, ENTITIES - 1)), gen);
            end
        end
    endtask

    initial begin
        for (int k = 0; k < ENTITIES; k++) begin
            plan_live[k] = 1'b0;
            plan_gen[k]  = '0;
        end

        // Directed opening: lookups on an empty table, the unused mode, adds at
        // the id and generation extremes, a duplicate add, a get with the wrong
        // generation, a remove with the wrong generation, removes that move the
        // last entry into the hole, and removes of the last slot itself.
        queue_beat(MODE_GET,    8'h00, 16'h0000);
        queue_beat(MODE_REMOVE, 8'h00, 16'h0000);
        queue_beat(MODE_NONE,   8'h55, 16'hAAAA);
        queue_beat(MODE_ADD,    8'h00, 16'h0000);
        queue_beat(MODE_ADD,    8'hFF, 16'hFFFF);
        queue_beat(MODE_ADD,    8'h80, 16'h1234);
        queue_beat(MODE_ADD,    8'h00, 16'h5555);
        queue_beat(MODE_GET,    8'hFF, 16'hFFFF);
        queue_beat(MODE_GET,    8'hFF, 16'h7FFF);
        queue_beat(MODE_REMOVE, 8'hFF, 16'h0000);
        queue_beat(MODE_NONE,   8'hFF, 16'hFFFF);
        queue_beat(MODE_REMOVE, 8'h00, 16'h0000);
        queue_beat(MODE_GET,    8'h80, 16'h1234);
        queue_beat(MODE_REMOVE, 8'h80, 16'h1234);
        queue_beat(MODE_REMOVE, 8'hFF, 16'hFFFF);
        queue_beat(MODE_GET,    8'hFF, 16'hFFFF);
        queue_beat(MODE_ADD,    8'h01, 16'h0001);
        queue_beat(MODE_ADD,    8'hFE, 16'hFFFE);
        queue_beat(MODE_REMOVE, 8'hFE, 16'hFFFE);
        queue_beat(MODE_REMOVE, 8'h01, 16'h0001);
        plan_random_beats();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Sampled at the clock edge, start still shows the beat being taken,
        // so the loop cannot end between an accept and its expectation.
        while (pending_beats.size() != 0 || start || table_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Driver. A beat is taken at an edge where start is high and busy is low;
    // the expectation is worked out right there, since the table holds only
    // one beat in flight and results come back in order. Start may be raised
    // while busy is high and then simply waits. Idle bursts may begin on any
    // free cycle, so they land before, during and after the table's busy
    // window; the burst rate is redrawn every 64 beats, which gives stretches
    // with no idling at all, and the tail has none.
    // ------------------------------------------------------------------------
    t_beat cur_beat;
    int    idle_left   = 0;
    int    idle_pct    = 20;
    int    beats_taken = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                table_results.push_back(predict_table(cur_beat));
                beats_taken++;
                if (beats_taken % 64 == 0)
                    case ($urandom_range(0, 2))
                        0:       idle_pct = 0;
                        1:       idle_pct = 15;
                        default: idle_pct = 40;
                    endcase
            end
            if (!start || !busy) begin
                if (idle_left == 0 && pending_beats.size() > TAIL_BEATS
                        && $urandom_range(0, 99) < idle_pct)
                    idle_left = $urandom_range(1, 6);
                if (idle_left != 0) begin
                    // Junk on the payload while start is low must be ignored.
                    idle_left--;
                    start        <= 1'b0;
                    i_mode       <= MODE_W'($urandom);
                    i_entity_id  <= ID_W'($urandom);
                    i_entity_gen <= GEN_W'($urandom);
                end else if (pending_beats.size() != 0) begin
                    cur_beat      = pending_beats.pop_front();
                    start        <= 1'b1;
                    i_mode       <= cur_beat.mode;
                    i_entity_id  <= cur_beat.id;
                    i_entity_gen <= cur_beat.gen;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. Every result strobe is matched against the oldest expectation,
    // field by field; a strobe with nothing outstanding is a failure too.
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        fail_count++;
        if (fail_count <= 40)
            $display("%0t ns: %s", $realtime, what);
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid) begin
            if (table_results.size() == 0) begin
                report_mismatch("result beat with no request outstanding");
            end else begin
                want = table_results.pop_front();
                if (o_status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              o_status, want.status));
                if (o_slot_index !== want.slot)
                    report_mismatch($sformatf("slot_index %0d, expected %0d",
                                              o_slot_index, want.slot));
                if (o_moved_valid !== want.moved)
                    report_mismatch($sformatf("moved_valid %0d, expected %0d",
                                              o_moved_valid, want.moved));
                if (o_moved_from !== want.from)
                    report_mismatch($sformatf("moved_from %0d, expected %0d",
                                              o_moved_from, want.from));
                if (o_entry_total !== want.total)
                    report_mismatch($sformatf("entry_total %0d, expected %0d",
                                              o_entry_total, want.total));
            end
        end
    end

    // A hung handshake or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

endmodule
